>>> src/lmph_pkg.sv
// Shared types, constants and calibration table of the level meter.
package lmph_pkg;

	// configuration register file
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_LEVEL_OFFSET  = 3'd0,
		REG_LINEAR_SCALE  = 3'd1,
		REG_LINEAR_OFFSET = 3'd2,
		REG_BAR_MIN_DB    = 3'd3,
		REG_BAR_MAX_DB    = 3'd4,
		REG_HOLD_TIME_MS  = 3'd5,
		REG_RELEASE_RATE  = 3'd6
	} lmph_reg_t;

	typedef struct packed {
		logic [15:0] level_offset;
		logic [15:0] linear_scale;
		logic [15:0] linear_offset;
		logic [6:0]  bar_min_db;
		logic [6:0]  bar_max_db;
		logic [15:0] hold_time_ms;
		logic [15:0] release_rate;
	} lmph_cfg_t;

	localparam logic [15:0] RST_LEVEL_OFFSET  = 16'd10240;
	localparam logic [15:0] RST_LINEAR_SCALE  = 16'd4751;
	localparam logic [15:0] RST_LINEAR_OFFSET = 16'(-1894);
	localparam logic [6:0]  RST_BAR_MIN_DB    = 7'd60;
	localparam logic [6:0]  RST_BAR_MAX_DB    = 7'd110;
	localparam logic [15:0] RST_HOLD_TIME_MS  = 16'd500;
	localparam logic [15:0] RST_RELEASE_RATE  = 16'd5120;

	// block parameters
	localparam int BAR_LEDS_DEF   = 91;
	localparam int CAL_POINTS_DEF = 7;

	// input floor, -60 dB in Q8.8
	localparam logic signed [15:0] FLOOR_DB = -16'sd15360;

	// calibration table, Q8.8 dB, entries beyond the used points are zero
	localparam int CAL_TBL_MAX = 16;
	localparam int CAL_IDX_W   = 4;
	localparam logic signed [15:0] CAL_X [CAL_TBL_MAX] = '{
		16'sd15104, 16'sd15616, 16'sd17664, 16'sd19200, 16'sd20736, 16'sd21760,
		16'sd23040, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		16'sd0, 16'sd0
	};
	localparam logic signed [15:0] CAL_Y [CAL_TBL_MAX] = '{
		16'sd16640, 16'sd18176, 16'sd20480, 16'sd21760, 16'sd23040, 16'sd24320,
		16'sd24832, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		16'sd0, 16'sd0
	};

	// shared multiplier
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 18;
	localparam int PROD_W = MUL_AW + MUL_BW;

	// shared divider: quotient below 2^DIV_QW, numerator below den * 2^DIV_QW
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 17;
	localparam int DIV_QW = 17;

	localparam logic [DIV_DW-1:0] SMOOTH_DIV = DIV_DW'(5);
	localparam logic [DIV_DW-1:0] MS_PER_S   = DIV_DW'(1000);

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} lmph_div_req_t;

	typedef struct packed {
		logic              busy;
		logic [DIV_QW-1:0] quot;
	} lmph_div_rsp_t;

endpackage

>>> src/lmph_if.sv
// Valid/ready channel interfaces for level items and meter results.
interface lmph_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] level_db;
	logic [31:0]        now_ms;

	modport source(output valid, level_db, now_ms, input ready);
	modport sink(input valid, level_db, now_ms, output ready);
endinterface

interface lmph_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] display_db;
	logic [6:0]        lit_count;
	logic [6:0]        peak_index;
	logic              peak_shown;

	modport source(output valid, display_db, lit_count, peak_index, peak_shown, input ready);
	modport sink(input valid, display_db, lit_count, peak_index, peak_shown, output ready);
endinterface

>>> src/level_meter_peak_hold_top.sv
// Level meter with attack/release smoothing, bar mapping and peak hold.
//
// Input channel in_ch carries one measured level (Q8.8 dB) and a ms timestamp
// per item; output channel out_ch returns exactly one result per item: whole
// dB display value, lit LED count, peak marker position and marker flag.
// The APB port writes the seven calibration and bar registers at 4*index;
// write only while no item is in flight.
// An item runs through one shared multiplier and one shared radix-2 divider
// under a sequencer. An item needs the smoothing division plus up to three
// more (table interpolation, bar mapping, peak decay). The next item is
// taken only once the last one has handed its result to the output
// register; in_ch.ready is high only while the sequencer is idle.
// The result sits in an output register; when out_ch stalls, the sequencer
// holds the finished item until the register drains, then takes the next one.
// Reset loads the register defaults and clears smoothing and peak state.
module level_meter_peak_hold_top
	import lmph_pkg::*;
#(
	parameter int BAR_LEDS   = BAR_LEDS_DEF,
	parameter int CAL_POINTS = CAL_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	lmph_in_if.sink           in_ch,
	lmph_out_if.source        out_ch
);

	lmph_cfg_t cfg;

	lmph_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lmph_core #(
		.BAR_LEDS   (BAR_LEDS),
		.CAL_POINTS (CAL_POINTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

>>> src/lmph_cfg.sv
// APB configuration registers of the level meter.
module lmph_cfg
	import lmph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output lmph_cfg_t         cfg
);

	lmph_cfg_t cfg_q;
	lmph_reg_t reg_sel;

	assign reg_sel = lmph_reg_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_offset  <= RST_LEVEL_OFFSET;
			cfg_q.linear_scale  <= RST_LINEAR_SCALE;
			cfg_q.linear_offset <= RST_LINEAR_OFFSET;
			cfg_q.bar_min_db    <= RST_BAR_MIN_DB;
			cfg_q.bar_max_db    <= RST_BAR_MAX_DB;
			cfg_q.hold_time_ms  <= RST_HOLD_TIME_MS;
			cfg_q.release_rate  <= RST_RELEASE_RATE;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_LEVEL_OFFSET:  cfg_q.level_offset  <= pwdata[15:0];
				REG_LINEAR_SCALE:  cfg_q.linear_scale  <= pwdata[15:0];
				REG_LINEAR_OFFSET: cfg_q.linear_offset <= pwdata[15:0];
				REG_BAR_MIN_DB:    cfg_q.bar_min_db    <= pwdata[6:0];
				REG_BAR_MAX_DB:    cfg_q.bar_max_db    <= pwdata[6:0];
				REG_HOLD_TIME_MS:  cfg_q.hold_time_ms  <= pwdata[15:0];
				REG_RELEASE_RATE:  cfg_q.release_rate  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LEVEL_OFFSET:  prdata = DATA_W'(cfg_q.level_offset);
			REG_LINEAR_SCALE:  prdata = DATA_W'(cfg_q.linear_scale);
			REG_LINEAR_OFFSET: prdata = DATA_W'(cfg_q.linear_offset);
			REG_BAR_MIN_DB:    prdata = DATA_W'(cfg_q.bar_min_db);
			REG_BAR_MAX_DB:    prdata = DATA_W'(cfg_q.bar_max_db);
			REG_HOLD_TIME_MS:  prdata = DATA_W'(cfg_q.hold_time_ms);
			REG_RELEASE_RATE:  prdata = DATA_W'(cfg_q.release_rate);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> src/lmph_div.sv
// Shared restoring divider, one quotient bit per cycle.
module lmph_div
	import lmph_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  lmph_div_req_t req,
	output lmph_div_rsp_t rsp
);

	localparam int SH_W  = DIV_DW + DIV_QW - 1;
	localparam int CNT_W = $clog2(DIV_QW + 1);

	logic [DIV_NW-1:0] rem_q;
	logic [SH_W-1:0]   dsh_q;
	logic [DIV_QW-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW:0]   trial;
	logic              fits;

	assign trial    = (DIV_NW + 1)'(rem_q) - (DIV_NW + 1)'(dsh_q);
	assign fits     = !trial[DIV_NW];
	assign rsp.busy = (cnt_q != '0);
	assign rsp.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
		end else if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= {req.den, {(DIV_QW - 1){1'b0}}};
			quot_q <= '0;
			cnt_q  <= CNT_W'(DIV_QW);
		end else if (cnt_q != '0) begin
			// subtract the shifted divisor where it fits
			if (fits) begin
				rem_q <= trial[DIV_NW-1:0];
			end
			quot_q <= {quot_q[DIV_QW-2:0], fits};
			dsh_q  <= dsh_q >> 1;
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

endmodule

>>> src/lmph_core.sv
// Sequencer and datapath: calibration, smoothing, bar mapping and peak hold.
module lmph_core
	import lmph_pkg::*;
#(
	parameter int BAR_LEDS   = BAR_LEDS_DEF,
	parameter int CAL_POINTS = CAL_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lmph_cfg_t   cfg,
	lmph_in_if.sink     in_ch,
	lmph_out_if.source  out_ch
);

	localparam int LIT_W = $clog2(BAR_LEDS + 1);
	localparam logic [LIT_W-1:0]     BAR_FULL  = LIT_W'(BAR_LEDS);
	localparam logic [CAL_IDX_W-1:0] CAL_LAST  = CAL_IDX_W'(CAL_POINTS - 1);
	localparam logic signed [PROD_W-1:0] DEC_LIMIT =
		PROD_W'(1000) << DIV_QW;

	typedef enum logic [4:0] {
		S_IDLE, S_GAIN, S_BEFORE, S_SEG, S_INTERP, S_CMUL, S_CDIV, S_CWAIT,
		S_SMOOTH, S_SWAIT, S_DISP, S_LIT, S_LMUL, S_LDIV, S_LWAIT,
		S_PEAK, S_DMUL, S_DDIV, S_DWAIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEG_LO, SEG_MID, SEG_HI
	} seg_mode_t;

	state_t                    state_q;
	seg_mode_t                 mode_q;
	logic signed [17:0]        x_q;
	logic [31:0]               now_q;
	logic signed [23:0]        bx_q;
	logic [CAL_IDX_W-1:0]      seg_q;
	logic [DIV_DW-1:0]         fx_q;
	logic signed [DIV_DW-1:0]  dy_q;
	logic [DIV_DW-1:0]         dx_q;
	logic signed [15:0]        y0_q;
	logic                      neg_q;
	logic signed [15:0]        cal_q;
	logic signed [15:0]        smooth_q;
	logic signed [7:0]         disp_q;
	logic [LIT_W-1:0]          lit_q;
	logic [15:0]               peak_q;
	logic [31:0]               pstart_q;
	logic [31:0]               plast_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      out_valid_q;
	logic signed [7:0]         out_disp_q;
	logic [6:0]                out_lit_q;
	logic [6:0]                out_pidx_q;
	logic                      out_shown_q;

	logic signed [15:0]        lvl_cl;
	logic signed [17:0]        x_n;
	logic signed [MUL_AW-1:0]  mul_a;
	logic signed [MUL_BW-1:0]  mul_b;
	logic signed [23:0]        bx_n;
	logic                      seg_lo;
	logic                      seg_hit;
	logic [CAL_IDX_W-1:0]      seg_idx;
	logic signed [15:0]        xi, xp, yi, yp;
	logic signed [DIV_DW-1:0]  dx_s;
	logic signed [PROD_W-1:0]  prod_abs;
	logic signed [25:0]        cal_interp;
	logic signed [16:0]        diff;
	logic signed [17:0]        rise_num, fall_num;
	logic signed [15:0]        disp_sh;
	logic signed [8:0]         lnum;
	logic [15:0]               lit16;
	logic [15:0]               gap;
	logic                      dec_sat;
	logic [16:0]               ceil_sum;
	logic [8:0]                pidx;
	lmph_div_req_t             div_req;
	lmph_div_rsp_t             div_rsp;

	function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
		if (v > 26'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -26'sd32768) begin
			return 16'sh8000;
		end else begin
			return 16'(v);
		end
	endfunction

	lmph_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.display_db = out_disp_q;
	assign out_ch.lit_count  = out_lit_q;
	assign out_ch.peak_index = out_pidx_q;
	assign out_ch.peak_shown = out_shown_q;

	// input clamp and level offset
	assign lvl_cl = (in_ch.level_db < FLOOR_DB) ? FLOOR_DB : in_ch.level_db;
	assign x_n    = 18'(lvl_cl) + 18'($signed(cfg.level_offset));

	// gain product rounded to Q8.8 (ties up), then linear offset
	assign bx_n = 24'(((prod_q + PROD_W'(2048)) >>> 12) + PROD_W'($signed(cfg.linear_offset)));

	// first table point at or above the level
	always_comb begin
		seg_hit = 1'b0;
		seg_idx = CAL_LAST;
		for (int i = CAL_TBL_MAX - 1; i >= 1; i--) begin
			if (i < CAL_POINTS && bx_q <= 24'(CAL_X[i])) begin
				seg_hit = 1'b1;
				seg_idx = CAL_IDX_W'(i);
			end
		end
		seg_lo = (bx_q <= 24'(CAL_X[0]));
	end

	assign xi   = CAL_X[seg_q];
	assign xp   = CAL_X[seg_q - CAL_IDX_W'(1)];
	assign yi   = CAL_Y[seg_q];
	assign yp   = CAL_Y[seg_q - CAL_IDX_W'(1)];
	assign dx_s = DIV_DW'(xi) - DIV_DW'(xp);

	assign prod_abs   = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign cal_interp = neg_q ? 26'(y0_q) - $signed({9'b0, div_rsp.quot})
	                          : 26'(y0_q) + $signed({9'b0, div_rsp.quot});

	// smoothing step numerators, rounded to nearest
	assign diff     = 17'(cal_q) - 17'(smooth_q);
	assign rise_num = 18'(diff) + 18'(diff) + 18'sd2;
	assign fall_num = 18'sd2 - 18'(diff);

	// truncate toward zero to whole dB
	assign disp_sh = (smooth_q < 0 && smooth_q[7:0] != 8'd0) ? (smooth_q >>> 8) + 16'sd1
	                                                         : (smooth_q >>> 8);

	assign lnum    = 9'(disp_q) - $signed({2'b00, cfg.bar_min_db});
	assign lit16   = {8'(lit_q), 8'b0};
	assign gap     = peak_q - lit16;
	assign dec_sat = (prod_q >= DEC_LIMIT);

	assign ceil_sum = 17'(peak_q) + 17'd255;
	assign pidx     = (ceil_sum[16:8] - 9'd1 > 9'(BAR_LEDS - 1)) ? 9'(BAR_LEDS - 1)
	                                                             : ceil_sum[16:8] - 9'd1;

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_GAIN: begin
				mul_a = MUL_AW'(x_q);
				mul_b = $signed({2'b00, cfg.linear_scale});
			end
			S_CMUL: begin
				mul_a = $signed({(MUL_AW - DIV_DW)'(0), fx_q});
				mul_b = MUL_BW'(dy_q);
			end
			S_LMUL: begin
				mul_a = MUL_AW'(lnum);
				mul_b = MUL_BW'(BAR_LEDS);
			end
			S_DMUL: begin
				mul_a = $signed({1'b0, now_q - plast_q});
				mul_b = $signed({2'b00, cfg.release_rate});
			end
			default: ;
		endcase
	end

	// request to the shared divider
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			S_CDIV: begin
				div_req.start = 1'b1;
				div_req.num   = prod_abs[DIV_NW-1:0];
				div_req.den   = dx_q;
			end
			S_SMOOTH: begin
				div_req.start = 1'b1;
				div_req.num   = (diff > 0) ? DIV_NW'(unsigned'(rise_num))
				                           : DIV_NW'(unsigned'(fall_num));
				div_req.den   = SMOOTH_DIV;
			end
			S_LDIV: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q[DIV_NW-1:0];
				div_req.den   = DIV_DW'(7'(cfg.bar_max_db - cfg.bar_min_db));
			end
			S_DDIV: begin
				div_req.start = !dec_sat;
				div_req.num   = prod_q[DIV_NW-1:0];
				div_req.den   = MS_PER_S;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= SEG_LO;
			x_q         <= '0;
			now_q       <= '0;
			bx_q        <= '0;
			seg_q       <= '0;
			fx_q        <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			y0_q        <= '0;
			neg_q       <= 1'b0;
			cal_q       <= '0;
			smooth_q    <= '0;
			disp_q      <= '0;
			lit_q       <= '0;
			peak_q      <= '0;
			pstart_q    <= '0;
			plast_q     <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_disp_q  <= '0;
			out_lit_q   <= '0;
			out_pidx_q  <= '0;
			out_shown_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						x_q     <= x_n;
						now_q   <= in_ch.now_ms;
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_BEFORE;
				end
				S_BEFORE: begin
					bx_q    <= bx_n;
					state_q <= S_SEG;
				end
				S_SEG: begin
					seg_q   <= seg_idx;
					mode_q  <= seg_lo ? SEG_LO : (seg_hit ? SEG_MID : SEG_HI);
					state_q <= S_INTERP;
				end
				S_INTERP: begin
					case (mode_q)
						SEG_LO: begin
							cal_q   <= sat16(26'(bx_q) + 26'(CAL_Y[0]) - 26'(CAL_X[0]));
							state_q <= S_SMOOTH;
						end
						SEG_HI: begin
							cal_q   <= sat16(26'(bx_q) + 26'(CAL_Y[CAL_LAST])
							                 - 26'(CAL_X[CAL_LAST]));
							state_q <= S_SMOOTH;
						end
						default: begin
							if (dx_s <= 0) begin
								// flat segment takes its upper output
								cal_q   <= yi;
								state_q <= S_SMOOTH;
							end else begin
								fx_q    <= DIV_DW'(bx_q - 24'(xp));
								dx_q    <= unsigned'(dx_s);
								dy_q    <= DIV_DW'(yi) - DIV_DW'(yp);
								y0_q    <= yp;
								state_q <= S_CMUL;
							end
						end
					endcase
				end
				S_CMUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_CDIV;
				end
				S_CDIV: begin
					neg_q   <= prod_q[PROD_W-1];
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					if (!div_rsp.busy) begin
						cal_q   <= sat16(cal_interp);
						state_q <= S_SMOOTH;
					end
				end
				S_SMOOTH: begin
					neg_q   <= !(diff > 0);
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (!div_rsp.busy) begin
						smooth_q <= neg_q ? smooth_q - 16'(div_rsp.quot)
						                  : smooth_q + 16'(div_rsp.quot);
						state_q  <= S_DISP;
					end
				end
				S_DISP: begin
					disp_q  <= 8'(disp_sh);
					state_q <= S_LIT;
				end
				S_LIT: begin
					if (cfg.bar_max_db <= cfg.bar_min_db) begin
						lit_q   <= ($signed({disp_q[7], disp_q}) >=
						            $signed({2'b00, cfg.bar_min_db})) ? BAR_FULL : '0;
						state_q <= S_PEAK;
					end else if (lnum <= 0) begin
						lit_q   <= '0;
						state_q <= S_PEAK;
					end else begin
						state_q <= S_LMUL;
					end
				end
				S_LMUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_LDIV;
				end
				S_LDIV: begin
					state_q <= S_LWAIT;
				end
				S_LWAIT: begin
					if (!div_rsp.busy) begin
						lit_q   <= (div_rsp.quot > DIV_QW'(BAR_LEDS)) ? BAR_FULL
						                                              : LIT_W'(div_rsp.quot);
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (lit16 >= peak_q) begin
						peak_q   <= lit16;
						pstart_q <= now_q;
						state_q  <= S_OUT;
					end else if (now_q - pstart_q >= 32'(cfg.hold_time_ms)) begin
						state_q <= S_DMUL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DMUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_DDIV;
				end
				S_DDIV: begin
					// decay far beyond the gap drops straight to the bar
					if (dec_sat) begin
						peak_q  <= lit16;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (!div_rsp.busy) begin
						peak_q  <= (div_rsp.quot >= DIV_QW'(gap)) ? lit16
						                                         : peak_q - 16'(div_rsp.quot);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					plast_q <= now_q;
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_disp_q  <= disp_q;
						out_lit_q   <= 7'(lit_q);
						out_pidx_q  <= (peak_q != 16'd0) ? 7'(pidx) : 7'd0;
						out_shown_q <= (peak_q != 16'd0);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
